FILE: src/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Holds the request and response beat structures, command, status and register codes.
// No dependencies.
package ffha_pkg;

	localparam int ADDR_W     = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_OOM   = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_RANGE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] HEAP_BASE_RESET  = 32'd0;
	localparam logic [CFG_DATA_W-1:0] HEAP_LIMIT_RESET = 32'd65536;

	typedef struct packed {
		logic              command;
		logic [ADDR_W-1:0] request_bytes;
		logic [ADDR_W-1:0] block_pointer;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] granted_pointer;
		logic [1:0]        status;
		logic              from_free_list;
	} rsp_t;

endpackage

FILE: src/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the free list and the header size store of the heap allocator.
// No dependencies.
module ffha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/first_fit_heap_allocator_core.sv
// Top level of the first-fit heap allocator with bump fallback.
// Depends on ffha_pkg and ffha_ram (free list and header size store).
// A free checks the header and pushes its block onto the free list; an oversized allocate
// fails at once; other allocates scan the free list first-fit, compact it on a hit and else
// bump. The scan and compaction read the free-list RAM one entry per cycle. One request is in
// progress at a time; the next can be taken in the cycle the result beat is presented.
module first_fit_heap_allocator_core #(
	parameter int FREE_DEPTH   = 32,
	parameter int HEAP_BYTES   = 65536,
	parameter int ALIGN_BYTES  = 16,
	parameter int HEADER_BYTES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ffha_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  ffha_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output ffha_pkg::rsp_t                      rsp
);

	localparam int LA       = $clog2(ALIGN_BYTES);
	localparam int GRANULES = HEAP_BYTES / ALIGN_BYTES;
	localparam int GW       = $clog2(GRANULES);
	localparam int OW       = GW + LA;
	localparam int SW       = $clog2(HEAP_BYTES) + 1;
	localparam int FW       = 32 + SW;
	localparam int IW       = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
	localparam int CW       = $clog2(FREE_DEPTH + 1);

	localparam logic [33:0] ROUND_ADD  = 34'(ALIGN_BYTES - 1);
	localparam logic [33:0] ROUND_MASK = ~ROUND_ADD;
	localparam logic [33:0] TOTAL_ADD  = 34'(HEADER_BYTES + ALIGN_BYTES - 1);
	localparam logic [31:0] HDR        = 32'(HEADER_BYTES);
	localparam logic [32:0] HEAP_SPAN  = 33'(HEAP_BYTES);
	localparam logic [CW:0] DEPTH_C    = (CW + 1)'(FREE_DEPTH);

	typedef enum logic [13:0] {
		S_IDLE       = 14'b00000000000001,
		S_DECODE     = 14'b00000000000010,
		S_SCAN       = 14'b00000000000100,
		S_SHIFT_RD   = 14'b00000000001000,
		S_SHIFT      = 14'b00000000010000,
		S_BUMP_DIFF  = 14'b00000000100000,
		S_BUMP_ROUND = 14'b00000001000000,
		S_BUMP_ADD   = 14'b00000010000000,
		S_BUMP_END   = 14'b00000100000000,
		S_BUMP_CHECK = 14'b00001000000000,
		S_FREE_CHECK = 14'b00010000000000,
		S_FREE_READ  = 14'b00100000000000,
		S_FREE_PUSH  = 14'b01000000000000,
		S_DONE       = 14'b10000000000000
	} state_t;

	state_t          state_q;
	logic [31:0]     heap_base_q;
	logic [31:0]     heap_limit_q;
	logic [32:0]     uend_q;
	logic            started_q;
	logic [31:0]     bump_q;
	logic [CW-1:0]   count_q;
	logic            rsp_valid_q;
	ffha_pkg::rsp_t  rsp_q;
	ffha_pkg::rsp_t  res_q;

	logic            cmd_q;
	logic [31:0]     tot_q;
	logic            tot_ovf_q;
	logic [31:0]     ptr_q;
	logic [31:0]     h_q;
	logic [IW-1:0]   scan_idx_q;
	logic [IW-1:0]   sh_idx_q;
	logic [32:0]     diff_q;
	logic            lt_q;
	logic [33:0]     rnd_q;
	logic [33:0]     aligned_q;
	logic [34:0]     end_q;
	logic [GW-1:0]   g_q;

	logic            req_accept;
	logic [31:0]     req_nz;
	logic [33:0]     req_total;
	logic [32:0]     uend_sum;
	logic [CW:0]     cnt_x;
	logic [CW:0]     sh_x;
	logic            scan_hit;
	logic            shift_rd_last;
	logic            shift_last;
	logic [31:0]     bump_sel;
	logic            h_fail;
	logic            bump_fail;
	logic [OW-1:0]   h_off;
	logic [OW-1:0]   a_off;

	logic            fl_we;
	logic [IW-1:0]   fl_waddr;
	logic [FW-1:0]   fl_wdata;
	logic [IW-1:0]   fl_raddr;
	logic [FW-1:0]   fl_rdata;
	logic            hs_we;
	logic [SW-1:0]   hs_rdata;

	assign req_accept = req_valid && !req_stall;
	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign req_nz    = (req.request_bytes == '0) ? 32'd1 : req.request_bytes;
	assign req_total = ({2'b00, req_nz} + TOTAL_ADD) & ROUND_MASK;
	assign uend_sum  = {1'b0, heap_base_q} + HEAP_SPAN;

	assign cnt_x         = {1'b0, count_q};
	assign sh_x          = (CW + 1)'(sh_idx_q);
	assign scan_hit      = (32'(fl_rdata[SW-1:0]) >= tot_q);
	assign shift_rd_last = ((sh_x + (CW + 1)'(1)) >= cnt_x);
	assign shift_last    = ((sh_x + (CW + 1)'(2)) >= cnt_x);
	assign bump_sel      = lt_q ? bump_q : diff_q[31:0];

	assign h_off = h_q[OW-1:0] - heap_base_q[OW-1:0];
	assign a_off = aligned_q[OW-1:0] - heap_base_q[OW-1:0];

	assign h_fail = (h_q < heap_base_q) || (h_q >= bump_q) || ({1'b0, h_q} >= uend_q) ||
		(h_q[LA-1:0] != heap_base_q[LA-1:0]);
	assign bump_fail = (aligned_q[33:32] != 2'b00) || (end_q[34:32] != 3'b000) ||
		(aligned_q < {2'b00, heap_base_q}) || (end_q > {2'b00, uend_q});

	always_comb begin
		fl_we    = 1'b0;
		fl_waddr = sh_idx_q;
		fl_wdata = fl_rdata;
		fl_raddr = scan_idx_q - IW'(1);
		hs_we    = 1'b0;
		unique case (state_q)
			S_DECODE: begin
				fl_raddr = IW'(cnt_x - (CW + 1)'(1));
			end
			S_SHIFT_RD: begin
				fl_raddr = IW'(sh_x + (CW + 1)'(1));
			end
			S_SHIFT: begin
				fl_we    = 1'b1;
				fl_raddr = IW'(sh_x + (CW + 1)'(2));
			end
			S_FREE_PUSH: begin
				fl_we    = 1'b1;
				fl_waddr = IW'(count_q);
				fl_wdata = {h_q, hs_rdata};
			end
			S_BUMP_CHECK: begin
				hs_we = !bump_fail;
			end
			default: begin
			end
		endcase
	end

	ffha_ram #(
		.WIDTH(FW),
		.DEPTH(FREE_DEPTH)
	) u_free_list (
		.clk  (clk),
		.we   (fl_we),
		.waddr(fl_waddr),
		.wdata(fl_wdata),
		.raddr(fl_raddr),
		.rdata(fl_rdata)
	);

	ffha_ram #(
		.WIDTH(SW),
		.DEPTH(GRANULES)
	) u_header_store (
		.clk  (clk),
		.we   (hs_we),
		.waddr(g_q),
		.wdata(tot_q[SW-1:0]),
		.raddr(g_q),
		.rdata(hs_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= ffha_pkg::HEAP_BASE_RESET;
			heap_limit_q <= ffha_pkg::HEAP_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ffha_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_data;
				ffha_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						started_q <= 1'b1;
						state_q   <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (cmd_q == ffha_pkg::CMD_ALLOC) begin
						if (tot_ovf_q) begin
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							state_q <= S_BUMP_DIFF;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (ptr_q == '0 || ptr_q < HDR) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_FREE_CHECK;
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q <= S_SHIFT_RD;
					end else if (scan_idx_q == '0) begin
						state_q <= S_BUMP_DIFF;
					end
				end
				S_SHIFT_RD: begin
					if (shift_rd_last) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (shift_last) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_BUMP_DIFF:  state_q <= S_BUMP_ROUND;
				S_BUMP_ROUND: state_q <= S_BUMP_ADD;
				S_BUMP_ADD:   state_q <= S_BUMP_END;
				S_BUMP_END:   state_q <= S_BUMP_CHECK;
				S_BUMP_CHECK: state_q <= S_DONE;
				S_FREE_CHECK: state_q <= h_fail ? S_DONE : S_FREE_READ;
				S_FREE_READ:  state_q <= (cnt_x == DEPTH_C) ? S_DONE : S_FREE_PUSH;
				S_FREE_PUSH: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		uend_q <= ({1'b0, heap_limit_q} < uend_sum) ? {1'b0, heap_limit_q} : uend_sum;
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					cmd_q     <= req.command;
					tot_q     <= req_total[31:0];
					tot_ovf_q <= (req_total[33:32] != 2'b00);
					ptr_q     <= req.block_pointer;
					res_q     <= '0;
					if (!started_q) begin
						bump_q <= heap_base_q;
					end
				end
			end
			S_DECODE: begin
				scan_idx_q <= IW'(cnt_x - (CW + 1)'(1));
				h_q        <= ptr_q - HDR;
				if (cmd_q == ffha_pkg::CMD_ALLOC) begin
					if (tot_ovf_q) begin
						res_q.status <= ffha_pkg::STATUS_OOM;
					end
				end else if (ptr_q != '0 && ptr_q < HDR) begin
					res_q.status <= ffha_pkg::STATUS_RANGE;
				end
			end
			S_SCAN: begin
				scan_idx_q <= scan_idx_q - IW'(1);
				sh_idx_q   <= scan_idx_q;
				if (scan_hit) begin
					res_q.granted_pointer <= fl_rdata[FW-1:SW] + HDR;
					res_q.from_free_list  <= 1'b1;
				end
			end
			S_SHIFT: begin
				sh_idx_q <= sh_idx_q + IW'(1);
			end
			S_BUMP_DIFF: begin
				diff_q <= {1'b0, bump_q} - {1'b0, heap_base_q};
				lt_q   <= (bump_q < heap_base_q);
			end
			S_BUMP_ROUND: begin
				rnd_q <= ({2'b00, bump_sel} + ROUND_ADD) & ROUND_MASK;
			end
			S_BUMP_ADD: begin
				aligned_q <= lt_q ? rnd_q : rnd_q + {2'b00, heap_base_q};
			end
			S_BUMP_END: begin
				end_q <= {1'b0, aligned_q} + {3'b000, tot_q};
				g_q   <= a_off[OW-1:LA];
			end
			S_BUMP_CHECK: begin
				if (bump_fail) begin
					res_q.status <= ffha_pkg::STATUS_OOM;
				end else begin
					bump_q                <= end_q[31:0];
					res_q.granted_pointer <= aligned_q[31:0] + HDR;
				end
			end
			S_FREE_CHECK: begin
				g_q <= h_off[OW-1:LA];
				if (h_fail) begin
					res_q.status <= ffha_pkg::STATUS_RANGE;
				end
			end
			S_FREE_READ: begin
				if (cnt_x == DEPTH_C) begin
					res_q.status <= ffha_pkg::STATUS_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= DEPTH_C)
		else $error("free list count exceeds its depth");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> ($past(state_q) == S_SHIFT_RD || $past(state_q) == S_SHIFT ||
			$past(state_q) == S_FREE_PUSH))
		else $error("free list count changed outside compaction or push");

	a_reuse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.from_free_list |->
			rsp.status == ffha_pkg::STATUS_OK && rsp.granted_pointer != '0)
		else $error("reused block reported with a failure or a null pointer");

endmodule
